>>> src/arp_pkg.sv
// Shared codes and fixed widths of the arpeggiator note sequencer.
package arp_pkg;

    // Fixed field widths.
    localparam int CH_BITS        = 4;
    localparam int NUM_CH         = 16;
    localparam int RND_BITS       = 16;
    localparam int COUNT_OUT_BITS = 5;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 3;

    // Event codes.
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_DROP  = 2'd1;
    localparam logic [1:0] FUNC_CLOCK = 2'd2;
    localparam logic [1:0] FUNC_RESET = 2'd3;

    // Play modes.
    localparam logic [2:0] MODE_UP         = 3'd0;
    localparam logic [2:0] MODE_DOWN       = 3'd1;
    localparam logic [2:0] MODE_UPDOWN     = 3'd2;
    localparam logic [2:0] MODE_UPDOWN_REP = 3'd3;
    localparam logic [2:0] MODE_AS_PLAYED  = 3'd4;
    localparam logic [2:0] MODE_RANDOM     = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLAY_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOTES_IMM = 2'd1;

endpackage

>>> src/arp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/arp_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module arp_mod #(
    parameter int DW = 16,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [VW-1:0] o_rem
);

    localparam int NW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   r_rem;
    logic [VW:0]   n_trial;
    logic [VW:0]   n_rem;

    // One shift and conditional subtract.
    always_comb begin
        n_trial = {r_rem[VW-1:0], r_dvd[DW-1]};
        if (n_trial >= {1'b0, r_dvs}) begin
            n_rem = n_trial - {1'b0, r_dvs};
        end else begin
            n_rem = n_trial;
        end
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DW);
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[DW-2:0], 1'b0};
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[VW-1:0];

endmodule

>>> src/arpeggiator_note_sequencer.sv
// Top level of the arpeggiator note sequencer: event sequencer over two note RAMs.
//
//  Channel   Direction  Handshake              Payload
//  event     in         start / busy           i_func, i_channel, i_pitch, i_random_value
//  result    out        o_done strobe          o_pitch_out, o_note_fired, o_held_count
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// One item is worked at a time; busy is high from the cycle after acceptance to the
// result strobe. A drop of a held note and an add each walk the live RAM one entry per
// cycle, as does a copy resync. A clock step in the up and as-played modes waits on the
// serial remainder unit once and in the random mode twice; other modes do without it.
// Reset is synchronous and needs no clearing pass; the result cannot be stalled.
module arpeggiator_note_sequencer
    import arp_pkg::*;
#(
    parameter int MAX_NOTES  = 16,
    parameter int PITCH_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_func,
    input  logic [CH_BITS-1:0]          i_channel,
    input  logic signed [PITCH_BITS-1:0] i_pitch,
    input  logic [RND_BITS-1:0]         i_random_value,
    output logic                        o_done,
    output logic signed [PITCH_BITS-1:0] o_pitch_out,
    output logic                        o_note_fired,
    output logic [COUNT_OUT_BITS-1:0]   o_held_count,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int IW = $clog2(MAX_NOTES);
    localparam int CW = $clog2(MAX_NOTES + 1);
    localparam int PW = IW + 1;
    localparam int XW = PW + 1;
    localparam int PB = PITCH_BITS;
    localparam int EW = PB + CH_BITS;
    localparam int WW = 2 * EW;

    localparam logic signed [XW-1:0] X_ZERO = '0;
    localparam logic signed [XW-1:0] X_ONE  = XW'(1);
    localparam logic signed [XW-1:0] X_TWO  = XW'(2);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DROP   = 4'd1;
    localparam logic [3:0] ST_ADDCHK = 4'd2;
    localparam logic [3:0] ST_ADD    = 4'd3;
    localparam logic [3:0] ST_SYNC   = 4'd4;
    localparam logic [3:0] ST_STEP   = 4'd5;
    localparam logic [3:0] ST_MODP   = 4'd6;
    localparam logic [3:0] ST_MODR   = 4'd7;
    localparam logic [3:0] ST_READ   = 4'd8;
    localparam logic [3:0] ST_RDW    = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    // Control state.
    logic [3:0]           r_state;
    logic [2:0]           r_mode;
    logic                 r_imm;
    logic [NUM_CH-1:0]    r_note_on;
    logic [CW-1:0]        r_live_cnt;
    logic signed [PW-1:0] r_live_pos;
    logic                 r_live_up;
    logic                 r_changed;
    logic [CW-1:0]        r_copy_cnt;
    logic signed [PW-1:0] r_copy_pos;
    logic                 r_copy_up;
    logic                 r_resync_due;
    logic signed [PB-1:0] r_held;
    logic                 r_fired;

    // Latched item and walk registers.
    logic [1:0]           r_func;
    logic [CH_BITS-1:0]   r_ch;
    logic signed [PB-1:0] r_pitch;
    logic [RND_BITS-1:0]  r_rnd;
    logic [CW-1:0]        r_rd;
    logic                 r_av;
    logic [IW-1:0]        r_ai;
    logic [WW-1:0]        r_prev;
    logic                 r_fa;
    logic                 r_fb;
    logic [IW-1:0]        r_addr;

    // RAM ports.
    logic          l_we, c_we;
    logic [IW-1:0] l_wa, l_ra, c_wa;
    logic [WW-1:0] l_wd, c_wd, l_rd, c_rd;

    // Working signals.
    logic                 accept, ch_ok, in_walk, walk_go, walk_end, ins_now;
    logic [EW-1:0]        as_j, by_j, prev_as, prev_by, new_ent;
    logic [CW-1:0]        cur_cnt;
    logic signed [PW-1:0] cur_pos;
    logic                 cur_up, mode2, mode_mod;
    logic signed [XW-1:0] posx, nx, pinc, pdec, npos;
    logic                 nup, nend;
    logic                 mod_start, mod_done;
    logic [RND_BITS-1:0]  mod_dvd;
    logic [CW-1:0]        mod_rem;
    logic [WW-1:0]        rd_word;

    // Live set RAM: each word holds one as-played entry and one by-pitch entry.
    arp_ram #(.WIDTH(WW), .DEPTH(MAX_NOTES)) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_wa),
        .i_wdata (l_wd),
        .i_raddr (l_ra),
        .o_rdata (l_rd)
    );

    // Playback copy RAM, same layout.
    arp_ram #(.WIDTH(WW), .DEPTH(MAX_NOTES)) u_copy_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_wa),
        .i_wdata (c_wd),
        .i_raddr (r_addr),
        .o_rdata (c_rd)
    );

    // Remainder unit for position wrap and random pick.
    arp_mod #(.DW(RND_BITS), .VW(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (cur_cnt),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign accept  = start && !busy;
    assign busy    = (r_state != ST_IDLE);
    assign ch_ok   = (int'(i_channel) < MAX_NOTES);

    // Walk over the live RAM, one read per cycle, data arriving in the cycle after.
    assign in_walk  = (r_state == ST_DROP) || (r_state == ST_ADD) || (r_state == ST_SYNC);
    assign walk_go  = (r_rd < r_live_cnt);
    assign walk_end = !walk_go && !r_av;
    assign l_ra     = in_walk ? r_rd[IW-1:0] : r_addr;

    assign as_j    = l_rd[WW-1:EW];
    assign by_j    = l_rd[EW-1:0];
    assign prev_as = r_prev[WW-1:EW];
    assign prev_by = r_prev[EW-1:0];
    assign new_ent = {r_ch, r_pitch};
    assign ins_now = r_fa || (r_pitch < $signed(by_j[PB-1:0]));

    // Write-back: shift down on drop, insert on add, copy on resync.
    always_comb begin
        l_we = 1'b0;
        l_wa = r_ai;
        l_wd = l_rd;
        c_we = 1'b0;
        c_wa = r_ai;
        c_wd = l_rd;
        case (r_state)
            ST_DROP: begin
                if (r_av && (r_ai != '0)) begin
                    l_we = 1'b1;
                    l_wa = r_ai - IW'(1);
                    l_wd = {(r_fa ? as_j : prev_as), (r_fb ? by_j : prev_by)};
                end
            end
            ST_ADD: begin
                if (r_av) begin
                    l_we = 1'b1;
                    l_wd = {as_j, (r_fa ? prev_by : (ins_now ? new_ent : by_j))};
                end else if (walk_end) begin
                    l_we = 1'b1;
                    l_wa = r_live_cnt[IW-1:0];
                    l_wd = {new_ent, (r_fa ? prev_by : new_ent)};
                end
            end
            ST_SYNC: begin
                c_we = r_av;
            end
            default: begin
                l_we = 1'b0;
            end
        endcase
    end

    // Next position for the direct modes.
    assign cur_cnt  = r_imm ? r_live_cnt : r_copy_cnt;
    assign cur_pos  = r_imm ? r_live_pos : r_copy_pos;
    assign cur_up   = r_imm ? r_live_up : r_copy_up;
    assign mode2    = (r_mode == MODE_UPDOWN);
    assign mode_mod = (r_mode inside {MODE_UP, MODE_AS_PLAYED, MODE_RANDOM});
    assign posx     = XW'(cur_pos);
    assign nx       = XW'(cur_cnt);
    assign pinc     = posx + X_ONE;
    assign pdec     = posx - X_ONE;

    always_comb begin
        npos = pinc;
        nup  = cur_up;
        nend = 1'b0;
        case (r_mode)
            MODE_DOWN: begin
                npos = pdec;
                if ((pdec < X_ZERO) || (pdec >= nx)) begin
                    npos = nx - X_ONE;
                end
                nend = (npos == X_ZERO);
            end
            MODE_UPDOWN, MODE_UPDOWN_REP: begin
                if (cur_up) begin
                    npos = pinc;
                    if (pinc >= nx) begin
                        if (mode2) begin
                            npos = (nx >= X_TWO) ? (nx - X_TWO) : X_ZERO;
                        end else begin
                            npos = nx - X_ONE;
                        end
                        nup = 1'b0;
                    end
                end else begin
                    npos = pdec;
                    if (pdec < X_ZERO) begin
                        npos = (mode2 && (nx != X_ONE)) ? X_ONE : X_ZERO;
                        nup  = 1'b1;
                    end
                    if (npos >= nx) begin
                        npos = nx - X_ONE;
                    end
                    nend = (npos == X_ZERO) || (mode2 && (npos == X_ONE));
                end
            end
            default: begin
                npos = pinc;
            end
        endcase
    end

    // Remainder requests: position wrap first, then the random pick.
    assign mod_start = ((r_state == ST_STEP) && (cur_cnt != '0) && mode_mod)
                     || ((r_state == ST_MODP) && mod_done && (r_mode == MODE_RANDOM));
    assign mod_dvd   = (r_state == ST_STEP) ? RND_BITS'($unsigned(pinc)) : r_rnd;

    assign rd_word = r_imm ? l_rd : c_rd;

    // Event sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= MODE_UP;
            r_imm        <= 1'b0;
            r_note_on    <= '0;
            r_live_cnt   <= '0;
            r_live_pos   <= '1;
            r_live_up    <= 1'b1;
            r_changed    <= 1'b0;
            r_copy_cnt   <= '0;
            r_copy_pos   <= '1;
            r_copy_up    <= 1'b1;
            r_resync_due <= 1'b0;
            r_held       <= '0;
            r_fired      <= 1'b0;
            r_rd         <= '0;
            r_av         <= 1'b0;
            r_fa         <= 1'b0;
            r_fb         <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PLAY_MODE) begin
                    r_mode <= i_cfg_data;
                end else if (i_cfg_index == CFG_NOTES_IMM) begin
                    r_imm <= i_cfg_data[0];
                end
            end

            // Walk bookkeeping shared by drop, add and resync.
            if (in_walk) begin
                r_av <= walk_go;
                r_ai <= r_rd[IW-1:0];
                if (walk_go) begin
                    r_rd <= r_rd + CW'(1);
                end
                if (r_av) begin
                    r_prev <= l_rd;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_func  <= i_func;
                        r_ch    <= i_channel;
                        r_pitch <= i_pitch;
                        r_rnd   <= i_random_value;
                        r_fired <= 1'b0;
                        r_rd    <= '0;
                        r_av    <= 1'b0;
                        r_fa    <= 1'b0;
                        r_fb    <= 1'b0;
                        case (i_func)
                            FUNC_ADD, FUNC_DROP: begin
                                if (!ch_ok) begin
                                    r_state <= ST_DONE;
                                end else if (r_note_on[i_channel]) begin
                                    r_note_on[i_channel] <= 1'b0;
                                    r_changed            <= 1'b1;
                                    r_state              <= ST_DROP;
                                end else if (i_func == FUNC_ADD) begin
                                    r_state <= ST_ADDCHK;
                                end else begin
                                    r_state <= ST_DONE;
                                end
                            end
                            FUNC_CLOCK: begin
                                if (!r_imm && r_resync_due) begin
                                    r_resync_due <= 1'b0;
                                    r_state      <= r_changed ? ST_SYNC : ST_STEP;
                                end else begin
                                    r_state <= ST_STEP;
                                end
                            end
                            default: begin
                                r_live_cnt <= '0;
                                r_live_pos <= '1;
                                r_live_up  <= 1'b1;
                                r_copy_cnt <= '0;
                                r_copy_pos <= '1;
                                r_copy_up  <= 1'b1;
                                r_note_on  <= '0;
                                r_state    <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DROP: begin
                    if (r_av) begin
                        if (!r_fa && (as_j[EW-1:PB] == r_ch)) begin
                            r_fa <= 1'b1;
                        end
                        if (!r_fb && (by_j[EW-1:PB] == r_ch)) begin
                            r_fb <= 1'b1;
                        end
                    end
                    if (walk_end) begin
                        if (r_fa && r_fb) begin
                            r_live_cnt <= r_live_cnt - CW'(1);
                        end
                        r_state <= (r_func == FUNC_ADD) ? ST_ADDCHK : ST_DONE;
                    end
                end
                ST_ADDCHK: begin
                    if (int'(r_live_cnt) >= MAX_NOTES) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_note_on[r_ch] <= 1'b1;
                        r_changed       <= 1'b1;
                        r_rd            <= '0;
                        r_av            <= 1'b0;
                        r_fa            <= 1'b0;
                        r_state         <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    if (r_av) begin
                        r_fa <= ins_now;
                    end
                    // The walk bookkeeping already leaves the valid flag low here.
                    if (walk_end) begin
                        r_live_cnt <= r_live_cnt + CW'(1);
                        r_rd       <= '0;
                        if ((r_live_cnt == '0) && !r_imm) begin
                            r_state <= ST_SYNC;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SYNC: begin
                    if (walk_end) begin
                        r_copy_cnt <= r_live_cnt;
                        r_copy_pos <= '1;
                        r_changed  <= 1'b0;
                        r_state    <= (r_func == FUNC_CLOCK) ? ST_STEP : ST_DONE;
                    end
                end
                ST_STEP: begin
                    if ((cur_cnt == '0) || (r_mode > MODE_RANDOM)) begin
                        r_state <= ST_DONE;
                    end else if (mode_mod) begin
                        r_state <= ST_MODP;
                    end else begin
                        if (r_imm) begin
                            r_live_pos <= npos[PW-1:0];
                            r_live_up  <= nup;
                        end else begin
                            r_copy_pos   <= npos[PW-1:0];
                            r_copy_up    <= nup;
                            r_resync_due <= nend;
                        end
                        r_addr  <= npos[IW-1:0];
                        r_state <= ST_READ;
                    end
                end
                ST_MODP: begin
                    if (mod_done) begin
                        if (r_imm) begin
                            r_live_pos <= PW'(mod_rem);
                        end else begin
                            r_copy_pos   <= PW'(mod_rem);
                            r_resync_due <= (mod_rem == (cur_cnt - CW'(1)));
                        end
                        r_addr  <= mod_rem[IW-1:0];
                        r_state <= (r_mode == MODE_RANDOM) ? ST_MODR : ST_READ;
                    end
                end
                ST_MODR: begin
                    if (mod_done) begin
                        r_addr  <= mod_rem[IW-1:0];
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_RDW;
                end
                ST_RDW: begin
                    // As-played order for the as-played and random modes, by-pitch otherwise.
                    if (mode_mod && (r_mode != MODE_UP)) begin
                        r_held <= $signed(rd_word[WW-CH_BITS-1:EW]);
                    end else begin
                        r_held <= $signed(rd_word[PB-1:0]);
                    end
                    r_fired <= 1'b1;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result ports.
    assign o_done       = (r_state == ST_DONE);
    assign o_pitch_out  = r_held;
    assign o_note_fired = r_fired;
    assign o_held_count = COUNT_OUT_BITS'(r_live_cnt);

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not make the block busy");

    // A result strobe only follows an accepted item or a cycle of work.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept || busy))
        else $error("result strobe without an item in work");

    // When idle, the note-on flags agree with the live note count.
    a_flags_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(r_note_on) == int'(r_live_cnt)))
        else $error("note-on flags disagree with live note count");

    // The live set never grows beyond its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_live_cnt) <= MAX_NOTES)
        else $error("live note count beyond capacity");

endmodule
